@@ src/sia_pkg.sv @@
// Shared constants for the segment intersection unit.
`default_nettype none
package sia_pkg;

  // Coordinates wider than this are taken at this width; the products stay exact.
  localparam int unsigned MaxCoordBits = 30;

  // Depth of the queue between the front and back parts.
  localparam int unsigned QueueDepth = 2;

endpackage
`default_nettype wire

@@ src/sia_front.sv @@
// Front part: differences, cross products, sign normalisation and hit classification.
`default_nettype none
module sia_front
  import sia_pkg::*;
#(
  parameter int unsigned CW = 16,
  parameter int unsigned EW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire logic [CW-1:0] a_start_x_i,
  input  wire logic [CW-1:0] a_start_y_i,
  input  wire logic [CW-1:0] a_end_x_i,
  input  wire logic [CW-1:0] a_end_y_i,
  input  wire logic [CW-1:0] b_start_x_i,
  input  wire logic [CW-1:0] b_start_y_i,
  input  wire logic [CW-1:0] b_end_x_i,
  input  wire logic [CW-1:0] b_end_y_i,
  output logic               push_o,
  input  wire logic          full_i,
  output logic [EW-1:0]      entry_o
);

  localparam int unsigned D = CW + 1;
  localparam int unsigned M = 2 * D;
  localparam int unsigned P = 2 * CW + 3;
  localparam int unsigned U = P - 1;

  logic [3:0] vld_q;
  logic       en;

  logic signed [CW-1:0] ax1_q, ay1_q, ax2_q, ay2_q, ax3_q, ay3_q, ax4_q, ay4_q;
  logic signed [D-1:0]  dax1_q, day1_q, dbx1_q, dby1_q, ox1_q, oy1_q;
  logic signed [D-1:0]  dax2_q, day2_q, dax3_q, day3_q, dax4_q, day4_q;
  logic signed [M-1:0]  p1_q, p2_q, p3_q, p4_q, p5_q, p6_q;
  logic signed [P-1:0]  den3_q, ns3_q, nt3_q, den4_q, ns4_q, nt4_q;
  logic                 hit;

  // The whole front advances unless its last stage holds a word the queue cannot take.
  assign en      = !vld_q[3] || !full_i;
  assign ready_o = en;
  assign push_o  = vld_q[3] && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  // Stage one: direction vectors and start offset.
  always_ff @(posedge clk_i) begin
    if (en) begin
      ax1_q  <= $signed(a_start_x_i);
      ay1_q  <= $signed(a_start_y_i);
      dax1_q <= $signed({a_end_x_i[CW-1], a_end_x_i}) - $signed({a_start_x_i[CW-1], a_start_x_i});
      day1_q <= $signed({a_end_y_i[CW-1], a_end_y_i}) - $signed({a_start_y_i[CW-1], a_start_y_i});
      dbx1_q <= $signed({b_end_x_i[CW-1], b_end_x_i}) - $signed({b_start_x_i[CW-1], b_start_x_i});
      dby1_q <= $signed({b_end_y_i[CW-1], b_end_y_i}) - $signed({b_start_y_i[CW-1], b_start_y_i});
      ox1_q  <= $signed({a_start_x_i[CW-1], a_start_x_i})
                - $signed({b_start_x_i[CW-1], b_start_x_i});
      oy1_q  <= $signed({a_start_y_i[CW-1], a_start_y_i})
                - $signed({b_start_y_i[CW-1], b_start_y_i});
    end
  end

  // Stage two: the six cross-product terms.
  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q   <= dax1_q * dby1_q;
      p2_q   <= day1_q * dbx1_q;
      p3_q   <= dax1_q * oy1_q;
      p4_q   <= day1_q * ox1_q;
      p5_q   <= dbx1_q * oy1_q;
      p6_q   <= dby1_q * ox1_q;
      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;
      dax2_q <= dax1_q;
      day2_q <= day1_q;
    end
  end

  // Stage three: denominator and both numerators.
  always_ff @(posedge clk_i) begin
    if (en) begin
      den3_q <= P'(p1_q) - P'(p2_q);
      ns3_q  <= P'(p3_q) - P'(p4_q);
      nt3_q  <= P'(p5_q) - P'(p6_q);
      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;
      dax3_q <= dax2_q;
      day3_q <= day2_q;
    end
  end

  // Stage four: make the denominator positive.
  always_ff @(posedge clk_i) begin
    if (en) begin
      den4_q <= den3_q[P-1] ? -den3_q : den3_q;
      ns4_q  <= den3_q[P-1] ? -ns3_q  : ns3_q;
      nt4_q  <= den3_q[P-1] ? -nt3_q  : nt3_q;
      ax4_q  <= ax3_q;
      ay4_q  <= ay3_q;
      dax4_q <= dax3_q;
      day4_q <= day3_q;
    end
  end

  // The denominator must be non-zero and both parameters must lie in the closed unit interval.
  assign hit = (den4_q != '0) && !ns4_q[P-1] && !nt4_q[P-1]
               && (ns4_q <= den4_q) && (nt4_q <= den4_q);

  assign entry_o = {hit, den4_q[U-1:0], ns4_q[U-1:0], nt4_q[U-1:0],
                    ax4_q, ay4_q, dax4_q, day4_q};

endmodule
`default_nettype wire

@@ src/sia_fifo.sv @@
// Short word queue between the front and back parts.
`default_nettype none
module sia_fifo
  import sia_pkg::*;
#(
  parameter int unsigned EW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [EW-1:0] data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output logic [EW-1:0]      data_o
);

  localparam int unsigned AW = $clog2(QueueDepth);

  logic [EW-1:0] mem_q [QueueDepth];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;

  assign full_o  = (cnt_q == (AW + 1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (AW + 1)'(push_i) - (AW + 1)'(pop_i);
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

@@ src/sia_back.sv @@
// Back part: pipelined fraction dividers, crossing point and the output register.
`default_nettype none
module sia_back
  import sia_pkg::*;
#(
  parameter int unsigned CW = 16,
  parameter int unsigned F  = 15,
  parameter int unsigned EW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          empty_i,
  input  wire logic [EW-1:0] entry_i,
  output logic               pop_o,
  output logic               valid_o,
  input  wire logic          ready_i,
  output logic               hit_o,
  output logic [F:0]         t_o,
  output logic [F:0]         s_o,
  output logic [CW-1:0]      x_o,
  output logic [CW-1:0]      y_o
);

  localparam int unsigned D = CW + 1;
  localparam int unsigned U = 2 * CW + 2;
  localparam int unsigned R = D + F + 2;

  logic                en;
  logic [F:0]          vld_q;
  logic                mv_q, ov_q;

  logic                hit_q  [F+1];
  logic [U-1:0]        den_q  [F+1];
  logic [U-1:0]        rs_q   [F+1];
  logic [U-1:0]        rt_q   [F+1];
  logic [F-1:0]        qs_q   [F+1];
  logic [F-1:0]        qt_q   [F+1];
  logic                os_q   [F+1];
  logic                ot_q   [F+1];
  logic signed [CW-1:0] ax_q  [F+1];
  logic signed [CW-1:0] ay_q  [F+1];
  logic signed [D-1:0]  dax_q [F+1];
  logic signed [D-1:0]  day_q [F+1];

  logic                 e_hit;
  logic [U-1:0]         e_den, e_ns, e_nt;
  logic signed [CW-1:0] e_ax, e_ay;
  logic signed [D-1:0]  e_dax, e_day;

  logic [F:0]           t_fin, s_fin;
  logic                 mhit_q;
  logic [F:0]           mt_q, ms_q;
  logic signed [CW-1:0] max_q, may_q;
  logic signed [R-1:0]  mpx_q, mpy_q;
  logic signed [R-1:0]  offx, offy;

  assign {e_hit, e_den, e_ns, e_nt, e_ax, e_ay, e_dax, e_day} = entry_i;

  // The back advances unless a result waits at the output.
  assign en    = !ov_q || ready_i;
  assign pop_o = en && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      mv_q  <= 1'b0;
      ov_q  <= 1'b0;
    end else if (en) begin
      vld_q <= {vld_q[F-1:0], pop_o};
      mv_q  <= vld_q[F];
      ov_q  <= mv_q;
    end
  end

  // Load stage: a numerator equal to the denominator gives exactly one.
  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q[0] <= e_hit;
      den_q[0] <= e_den;
      rs_q[0]  <= e_ns;
      rt_q[0]  <= e_nt;
      qs_q[0]  <= '0;
      qt_q[0]  <= '0;
      os_q[0]  <= (e_ns == e_den);
      ot_q[0]  <= (e_nt == e_den);
      ax_q[0]  <= e_ax;
      ay_q[0]  <= e_ay;
      dax_q[0] <= e_dax;
      day_q[0] <= e_day;
    end
  end

  // One restoring division step per stage for each parameter.
  for (genvar i = 0; i < F; i++) begin : g_div
    logic [U-1:0] s2, t2;
    logic         sge, tge;

    assign s2  = {rs_q[i][U-2:0], 1'b0};
    assign t2  = {rt_q[i][U-2:0], 1'b0};
    assign sge = (s2 >= den_q[i]);
    assign tge = (t2 >= den_q[i]);

    always_ff @(posedge clk_i) begin
      if (en) begin
        rs_q[i+1]  <= sge ? s2 - den_q[i] : s2;
        rt_q[i+1]  <= tge ? t2 - den_q[i] : t2;
        qs_q[i+1]  <= {qs_q[i][F-2:0], sge};
        qt_q[i+1]  <= {qt_q[i][F-2:0], tge};
        hit_q[i+1] <= hit_q[i];
        den_q[i+1] <= den_q[i];
        os_q[i+1]  <= os_q[i];
        ot_q[i+1]  <= ot_q[i];
        ax_q[i+1]  <= ax_q[i];
        ay_q[i+1]  <= ay_q[i];
        dax_q[i+1] <= dax_q[i];
        day_q[i+1] <= day_q[i];
      end
    end
  end

  assign t_fin = ot_q[F] ? (F + 1)'(1) << F : {1'b0, qt_q[F]};
  assign s_fin = os_q[F] ? (F + 1)'(1) << F : {1'b0, qs_q[F]};

  // Scale the first direction vector by t.
  always_ff @(posedge clk_i) begin
    if (en) begin
      mhit_q <= hit_q[F];
      mt_q   <= t_fin;
      ms_q   <= s_fin;
      max_q  <= ax_q[F];
      may_q  <= ay_q[F];
      mpx_q  <= dax_q[F] * $signed({1'b0, t_fin});
      mpy_q  <= day_q[F] * $signed({1'b0, t_fin});
    end
  end

  // Arithmetic shift rounds the offset toward minus infinity.
  assign offx = mpx_q >>> F;
  assign offy = mpy_q >>> F;

  // Output register; a miss gives zeros throughout.
  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_o <= mhit_q;
      t_o   <= mhit_q ? mt_q : '0;
      s_o   <= mhit_q ? ms_q : '0;
      x_o   <= mhit_q ? CW'(max_q + offx[CW-1:0]) : '0;
      y_o   <= mhit_q ? CW'(may_q + offy[CW-1:0]) : '0;
    end
  end

  assign valid_o = ov_q;

endmodule
`default_nettype wire

@@ src/segment_intersection_2d_unit.sv @@
// Top level of the segment intersection unit: front, queue and back.
// From accepting an input word to out_valid_o, the word passes three further
// front stages, the queue, a load stage, the one-bit-per-stage dividers, the
// scaling stage and the output register. Throughput: one word per cycle while
// neither side stalls; front and back stall independently across a two-word
// queue. Reset clears all valid flags and queue pointers at once.
`default_nettype none
module segment_intersection_2d_unit
  import sia_pkg::*;
#(
  parameter int unsigned COORD_BITS      = 16,
  parameter int unsigned PARAM_FRAC_BITS = 15
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [COORD_BITS-1:0] a_start_x_i,
  input  wire logic [COORD_BITS-1:0] a_start_y_i,
  input  wire logic [COORD_BITS-1:0] a_end_x_i,
  input  wire logic [COORD_BITS-1:0] a_end_y_i,
  input  wire logic [COORD_BITS-1:0] b_start_x_i,
  input  wire logic [COORD_BITS-1:0] b_start_y_i,
  input  wire logic [COORD_BITS-1:0] b_end_x_i,
  input  wire logic [COORD_BITS-1:0] b_end_y_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       hit_o,
  output logic [PARAM_FRAC_BITS:0]   first_param_o,
  output logic [PARAM_FRAC_BITS:0]   second_param_o,
  output logic [COORD_BITS-1:0]      cross_x_o,
  output logic [COORD_BITS-1:0]      cross_y_o
);

  localparam int unsigned CW = (COORD_BITS > MaxCoordBits) ? MaxCoordBits : COORD_BITS;
  localparam int unsigned F  = PARAM_FRAC_BITS;
  localparam int unsigned U  = 2 * CW + 2;
  localparam int unsigned EW = 1 + 3 * U + 2 * CW + 2 * (CW + 1);

  logic          push, full, pop, empty;
  logic [EW-1:0] wr_entry, rd_entry;
  logic [CW-1:0] x, y;

  sia_front #(.CW(CW), .EW(EW)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_i),
    .ready_o     (in_ready_o),
    .a_start_x_i (a_start_x_i[CW-1:0]),
    .a_start_y_i (a_start_y_i[CW-1:0]),
    .a_end_x_i   (a_end_x_i[CW-1:0]),
    .a_end_y_i   (a_end_y_i[CW-1:0]),
    .b_start_x_i (b_start_x_i[CW-1:0]),
    .b_start_y_i (b_start_y_i[CW-1:0]),
    .b_end_x_i   (b_end_x_i[CW-1:0]),
    .b_end_y_i   (b_end_y_i[CW-1:0]),
    .push_o      (push),
    .full_i      (full),
    .entry_o     (wr_entry)
  );

  sia_fifo #(.EW(EW)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (wr_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (rd_entry)
  );

  sia_back #(.CW(CW), .F(F), .EW(EW)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .entry_i (rd_entry),
    .pop_o   (pop),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .hit_o   (hit_o),
    .t_o     (first_param_o),
    .s_o     (second_param_o),
    .x_o     (x),
    .y_o     (y)
  );

  // Coordinates beyond the internal width read as zero above it.
  assign cross_x_o = COORD_BITS'(x);
  assign cross_y_o = COORD_BITS'(y);

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the segment intersection unit.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned CoordW = 16;
  localparam int unsigned FracW  = 15;
  localparam int unsigned NumRand = 1750;
  localparam longint unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [CoordW-1:0] asx, asy, aex, aey, bsx, bsy, bex, bey;
  } seg_pair_t;

  typedef struct packed {
    logic            hit;
    logic [FracW:0]  t_par;
    logic [FracW:0]  s_par;
    logic [CoordW-1:0] px;
    logic [CoordW-1:0] py;
  } crossing_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  seg_pair_t pair_q = '0;
  logic hit_o;
  logic [FracW:0] first_param_o, second_param_o;
  logic [CoordW-1:0] cross_x_o, cross_y_o;

  seg_pair_t pending_pairs[$];
  crossing_t expected_crossings[$];
  int unsigned error_count = 0;
  int unsigned hit_count = 0;
  int unsigned word_count = 0;
  longint unsigned cycle_count = 0;
  bit stimulus_done = 1'b0;

  segment_intersection_2d_unit #(
    .COORD_BITS(CoordW),
    .PARAM_FRAC_BITS(FracW)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .a_start_x_i(pair_q.asx),
    .a_start_y_i(pair_q.asy),
    .a_end_x_i(pair_q.aex),
    .a_end_y_i(pair_q.aey),
    .b_start_x_i(pair_q.bsx),
    .b_start_y_i(pair_q.bsy),
    .b_end_x_i(pair_q.bex),
    .b_end_y_i(pair_q.bey),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .hit_o(hit_o),
    .first_param_o(first_param_o),
    .second_param_o(second_param_o),
    .cross_x_o(cross_x_o),
    .cross_y_o(cross_y_o)
  );

  // Clock generation.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Truncated fraction num / den with FracW bits, saturating at one.
  function automatic longint unsigned frac_quotient(longint num, longint den);
    longint unsigned q;
    longint r;
    q = 0;
    r = num;
    if (num >= den) return longint'(1) << FracW;
    for (int i = 0; i < FracW; i++) begin
      r = r <<< 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  // Point along a direction, rounded towards minus infinity.
  function automatic longint along_dir(longint start, longint d, longint tp);
    longint prod;
    prod = d * tp;
    return start + (prod >>> FracW);
  endfunction

  // Expected crossing of the two segments of one word.
  function automatic crossing_t predict_crossing(seg_pair_t p);
    crossing_t c;
    longint ax, ay, dax, day, dbx, dby, ox, oy, den, ns, nt, tq, sq;
    c = '0;
    ax = longint'($signed(p.asx));
    ay = longint'($signed(p.asy));
    dax = longint'($signed(p.aex)) - ax;
    day = longint'($signed(p.aey)) - ay;
    dbx = longint'($signed(p.bex)) - longint'($signed(p.bsx));
    dby = longint'($signed(p.bey)) - longint'($signed(p.bsy));
    ox = ax - longint'($signed(p.bsx));
    oy = ay - longint'($signed(p.bsy));
    den = dax * dby - day * dbx;
    ns = dax * oy - day * ox;
    nt = dbx * oy - dby * ox;
    if (den == 0) return c;
    if (den < 0) begin
      den = -den;
      ns = -ns;
      nt = -nt;
    end
    if (ns < 0 || ns > den || nt < 0 || nt > den) return c;
    sq = frac_quotient(ns, den);
    tq = frac_quotient(nt, den);
    c.hit = 1'b1;
    c.t_par = tq[FracW:0];
    c.s_par = sq[FracW:0];
    c.px = CoordW'(along_dir(ax, dax, tq));
    c.py = CoordW'(along_dir(ay, day, tq));
    return c;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("MISMATCH word %0d %s: got %0h, expected %0h", word_count, what, got, want);
    error_count++;
  endtask

  function automatic seg_pair_t make_pair(int a, int b, int c, int d,
                                          int e, int f, int g, int h);
    seg_pair_t p;
    p.asx = a[CoordW-1:0]; p.asy = b[CoordW-1:0];
    p.aex = c[CoordW-1:0]; p.aey = d[CoordW-1:0];
    p.bsx = e[CoordW-1:0]; p.bsy = f[CoordW-1:0];
    p.bex = g[CoordW-1:0]; p.bey = h[CoordW-1:0];
    return p;
  endfunction

  // Segment pair with random ends around a random centre, one rising and one falling; they need not cross.
  function automatic seg_pair_t random_crossing(int span);
    int cx, cy;
    cx = $urandom_range(65535) - 32768;
    cy = $urandom_range(65535) - 32768;
    cx = (cx > 32767 - span) ? 32767 - span : ((cx < -32768 + span) ? -32768 + span : cx);
    cy = (cy > 32767 - span) ? 32767 - span : ((cy < -32768 + span) ? -32768 + span : cy);
    return make_pair(cx - int'($urandom_range(span)), cy - int'($urandom_range(span)),
                     cx + int'($urandom_range(span)), cy + int'($urandom_range(span)),
                     cx - int'($urandom_range(span)), cy + int'($urandom_range(span)),
                     cx + int'($urandom_range(span)), cy - int'($urandom_range(span)));
  endfunction

  // Stimulus: directed cases first, then random words.
  initial begin
    seg_pair_t p;
    int k;
    // Plain crossing, touching ends (parameters exactly one and zero).
    pending_pairs.push_back(make_pair(0, 0, 160, 160, 0, 160, 160, 0));
    pending_pairs.push_back(make_pair(0, 0, 160, 0, 160, -16, 160, 16));
    pending_pairs.push_back(make_pair(0, 0, 160, 0, 0, 0, 0, 160));
    pending_pairs.push_back(make_pair(16, 16, 16, 320, -160, 320, 160, 320));
    // Parallel, collinear overlapping and zero-length segments.
    pending_pairs.push_back(make_pair(0, 0, 160, 0, 0, 16, 160, 16));
    pending_pairs.push_back(make_pair(0, 0, 160, 0, 80, 0, 320, 0));
    pending_pairs.push_back(make_pair(50, 50, 50, 50, 0, 0, 100, 100));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    // Near misses past either end.
    pending_pairs.push_back(make_pair(0, 0, 160, 0, 161, -16, 161, 16));
    pending_pairs.push_back(make_pair(0, 0, 160, 0, 80, 1, 80, 160));
    // Coordinate extremes, then small coordinates.
    pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    pending_pairs.push_back(make_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
    pending_pairs.push_back(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
    pending_pairs.push_back(make_pair(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768));
    pending_pairs.push_back(make_pair(-32768, -32768, -32768, 32767, -32768, 0, 32767, 1));
    pending_pairs.push_back(make_pair(-1, -1, 1, 1, -1, 1, 1, -1));
    pending_pairs.push_back(make_pair(3, 0, 0, 7, 0, 0, 5, 3));
    pending_pairs.push_back(make_pair(0, 0, -160, -48, -100, 0, -20, -80));
    // Random part: mostly pairs around a random centre, some fully random words.
    for (k = 0; k < NumRand; k++) begin
      case ($urandom_range(9))
        0, 1, 2: p = {$urandom, $urandom, $urandom, $urandom};
        3, 4: p = random_crossing(32);
        5, 6: p = random_crossing(2000);
        default: p = random_crossing(16000);
      endcase
      pending_pairs.push_back(p);
    end
  end

  // Driver: bursts with random gaps; valid held until accepted.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_crossings.push_back(predict_crossing(pair_q));
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          pair_q <= pending_pairs.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(40, 1);
            gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
          stimulus_done <= 1'b1;
        end
      end
    end
  end

  // Monitor: stall pattern on the result side, then compare every word.
  int unsigned stall_phase = 0;
  always @(posedge clk_i) begin
    crossing_t want;
    if (rst_ni) begin
      stall_phase <= stall_phase + 1;
      case ((stall_phase / 256) % 3)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(3) != 0);
        default: out_ready_i <= (stall_phase % 7) < 3;
      endcase
      if (out_valid_o && out_ready_i) begin
        word_count++;
        if (expected_crossings.size() == 0) begin
          report_mismatch("result with nothing expected", 1, 0);
        end else begin
          want = expected_crossings.pop_front();
          if (want.hit) hit_count++;
          if (hit_o !== want.hit) report_mismatch("hit", hit_o, want.hit);
          if (first_param_o !== want.t_par)
            report_mismatch("first_param", first_param_o, want.t_par);
          if (second_param_o !== want.s_par)
            report_mismatch("second_param", second_param_o, want.s_par);
          if (cross_x_o !== want.px) report_mismatch("cross_x", cross_x_o, want.px);
          if (cross_y_o !== want.py) report_mismatch("cross_y", cross_y_o, want.py);
        end
      end
    end
  end

  // Reset, watchdog and end of run.
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!(stimulus_done && expected_crossings.size() == 0) && cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    if (cycle_count >= CycleLimit) begin
      $display("Timeout with %0d results outstanding", expected_crossings.size());
      $display("DONE: errors detected");
    end else begin
      repeat (60) @(posedge clk_i);
      $display("Checked %0d segment pairs, %0d of them crossing, over %0d cycles",
               word_count, hit_count, cycle_count);
      if (error_count == 0 && expected_crossings.size() == 0) begin
        $display("DONE: 0 errors");
      end else begin
        $display("DONE: errors detected");
      end
    end
    $finish;
  end

endmodule
